[rtl/aes_block_encrypt_macros.svh]
// Assertion macros for the AES block encryption checker.
// Used by aes_block_encrypt_chk.sv; no other dependencies.
`ifndef AES_BLOCK_ENCRYPT_MACROS_SVH
`define AES_BLOCK_ENCRYPT_MACROS_SVH

// check that a condition implies a property on the next edge
`define AESBE_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("aesbe check failed");

// check that a condition implies a property on the same edge
`define AESBE_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("aesbe check failed");

`endif

[rtl/aesbe_pkg.sv]
// Package for AES block encryption: request/result types, S-box, GF helpers.
// No dependencies.
`timescale 1ns / 1ps

package aesbe_pkg;

    localparam int KEY_SLOTS_DEF = 15;
    localparam int MIN_ROUNDS    = 10;
    localparam int SLOT_W        = 4;
    localparam int ROUNDS_W      = 4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] key_slot;
        logic [63:0]       block_hi;
        logic [63:0]       block_lo;
    } aesbe_req_t;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
    } aesbe_res_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [127:0]      data;
    } aesbe_kwr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } aesbe_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[rtl/aesbe_key_store.sv]
// Round key store: one write port, one registered read port.
// Depends on aesbe_pkg.
`timescale 1ns / 1ps

module aesbe_key_store #(
    parameter int KEY_SLOTS = aesbe_pkg::KEY_SLOTS_DEF
) (
    input  logic                        clk,
    input  aesbe_pkg::aesbe_kwr_t       wr,
    input  logic [aesbe_pkg::SLOT_W-1:0] rd_addr,
    output logic [127:0]                rd_data
);

    localparam int AW = $clog2(KEY_SLOTS);

    logic [127:0] mem [KEY_SLOTS];
    logic [127:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/aesbe_col_unit.sv]
// One column of a round: SubBytes, MixColumns (skipped in last round), AddRoundKey.
// Depends on aesbe_pkg.
`timescale 1ns / 1ps

module aesbe_col_unit (
    input  logic [31:0] col_in,
    input  logic [31:0] key_col,
    input  logic        last,
    output logic [31:0] col_out
);

    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    logic [31:0] mixed;

    always_comb
    begin
        a0 = aesbe_pkg::SBOX[col_in[31:24]];
        a1 = aesbe_pkg::SBOX[col_in[23:16]];
        a2 = aesbe_pkg::SBOX[col_in[15:8]];
        a3 = aesbe_pkg::SBOX[col_in[7:0]];
        d0 = aesbe_pkg::xtime(a0);
        d1 = aesbe_pkg::xtime(a1);
        d2 = aesbe_pkg::xtime(a2);
        d3 = aesbe_pkg::xtime(a3);
        mixed = {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                 a0 ^ d1 ^ d2 ^ a2 ^ a3,
                 a0 ^ a1 ^ d2 ^ d3 ^ a3,
                 d0 ^ a0 ^ a1 ^ a2 ^ d3};
        col_out = (last ? {a0, a1, a2, a3} : mixed) ^ key_col;
    end

endmodule

[rtl/aes_block_encrypt.sv]
// AES block encryption top level: sequencer, state shift register, key store.
// Depends on aesbe_pkg, aesbe_key_store, aesbe_col_unit.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at an
//   edge where start is high and busy is low. op=0 writes req into key slot
//   key_slot (slots at or above KEY_SLOTS are dropped) and busy stays low.
//   op=1 encrypts {block_hi, block_lo}; busy goes high for the whole run.
//   Config channel: cfg_data (round count) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is high while idle. Counts saturate to
//   10 .. KEY_SLOTS-1.
//   Sequencing: state ST_INIT does the initial key add, then ST_ROUND feeds
//   one 32-bit column per cycle through one column unit, the four columns of
//   each round in turn; ST_DONE raises done and res is taken at its end edge.
//   Back-to-back: busy falls at that edge, so the next encrypt is taken only
//   after the previous one is done; a key load leaves busy low.
//   Result: res is valid for the single cycle done is high; the receiver
//   cannot stall it.
//   Reset: rst_n clears the sequencer and sets the round count to 10; the
//   key store is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module aes_block_encrypt #(
    parameter int KEY_SLOTS = aesbe_pkg::KEY_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  aesbe_pkg::aesbe_req_t         req,
    output logic                          done,
    output aesbe_pkg::aesbe_res_t         res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aesbe_pkg::ROUNDS_W-1:0] cfg_data
);

    localparam logic [aesbe_pkg::ROUNDS_W-1:0] R_MIN = aesbe_pkg::ROUNDS_W'(aesbe_pkg::MIN_ROUNDS);
    localparam logic [aesbe_pkg::ROUNDS_W-1:0] R_MAX = aesbe_pkg::ROUNDS_W'(KEY_SLOTS - 1);

    aesbe_pkg::aesbe_state_t state_reg, state_next;
    logic [aesbe_pkg::ROUNDS_W-1:0] rounds_reg, rounds_next;
    logic [aesbe_pkg::ROUNDS_W-1:0] nr_reg, nr_next;
    logic [aesbe_pkg::ROUNDS_W-1:0] rnd_reg, rnd_next;
    logic [1:0] col_reg, col_next;
    logic [31:0] g_reg [4];
    logic [31:0] g_next [4];
    logic [31:0] ng_reg [4];
    logic [31:0] ng_next [4];

    aesbe_pkg::aesbe_kwr_t kwr;
    logic [127:0] key_q;
    logic [31:0] key_col, col_in, col_out;
    logic [127:0] blk;
    logic take;

    assign busy      = (state_reg != aesbe_pkg::ST_IDLE);
    assign cfg_ready = !busy;
    assign take      = start && !busy;
    assign blk       = {req.block_hi, req.block_lo};

    assign kwr.en   = take && (req.op == aesbe_pkg::OP_LOAD) &&
                      (req.key_slot < aesbe_pkg::SLOT_W'(KEY_SLOTS));
    assign kwr.addr = req.key_slot;
    assign kwr.data = blk;

    aesbe_key_store #(.KEY_SLOTS(KEY_SLOTS)) u_keys (
        .clk     (clk),
        .wr      (kwr),
        .rd_addr (rnd_next),
        .rd_data (key_q)
    );

    // ShiftRows: row r of output column c comes from column c+r
    always_comb
    begin
        col_in = {g_reg[col_reg][31:24],
                  g_reg[col_reg + 2'd1][23:16],
                  g_reg[col_reg + 2'd2][15:8],
                  g_reg[col_reg + 2'd3][7:0]};
        case (col_reg)
            2'd0:    key_col = key_q[127:96];
            2'd1:    key_col = key_q[95:64];
            2'd2:    key_col = key_q[63:32];
            default: key_col = key_q[31:0];
        endcase
    end

    aesbe_col_unit u_col (
        .col_in  (col_in),
        .key_col (key_col),
        .last    (rnd_reg == nr_reg),
        .col_out (col_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= aesbe_pkg::ST_IDLE;
            rounds_reg <= R_MIN;
            nr_reg     <= R_MIN;
            rnd_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rounds_reg <= rounds_next;
            nr_reg     <= nr_next;
            rnd_reg    <= rnd_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg  <= g_next;
        ng_reg <= ng_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        rounds_next = rounds_reg;
        nr_next     = nr_reg;
        rnd_next    = rnd_reg;
        col_next    = col_reg;
        g_next      = g_reg;
        ng_next     = ng_reg;
        done        = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            rounds_next = cfg_data;
        end
        unique case (state_reg)
            aesbe_pkg::ST_IDLE:
            begin
                rnd_next = '0;
                col_next = '0;
                if (take && (req.op == aesbe_pkg::OP_ENCRYPT))
                begin
                    state_next = aesbe_pkg::ST_INIT;
                    nr_next    = (rounds_reg < R_MIN) ? R_MIN :
                                 (rounds_reg > R_MAX) ? R_MAX : rounds_reg;
                    // column c holds rows 0..3 of input bytes c, 4+c, 8+c, 12+c
                    for (int c = 0; c < 4; c++)
                    begin
                        g_next[c] = {blk[127-8*c -: 8], blk[95-8*c -: 8],
                                     blk[63-8*c -: 8], blk[31-8*c -: 8]};
                    end
                end
            end
            aesbe_pkg::ST_INIT:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    g_next[c] = g_reg[c] ^ key_q[127-32*c -: 32];
                end
                rnd_next   = aesbe_pkg::ROUNDS_W'(1);
                state_next = aesbe_pkg::ST_ROUND;
            end
            aesbe_pkg::ST_ROUND:
            begin
                ng_next[0] = ng_reg[1];
                ng_next[1] = ng_reg[2];
                ng_next[2] = ng_reg[3];
                ng_next[3] = col_out;
                col_next   = col_reg + 2'd1;
                if (col_reg == 2'd3)
                begin
                    g_next = '{ng_reg[1], ng_reg[2], ng_reg[3], col_out};
                    if (rnd_reg == nr_reg)
                    begin
                        state_next = aesbe_pkg::ST_DONE;
                    end
                    else
                    begin
                        rnd_next = rnd_reg + 1'b1;
                    end
                end
            end
            aesbe_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = aesbe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = aesbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            res.cipher_hi[63-8*c -: 8] = g_reg[c][31:24];
            res.cipher_hi[31-8*c -: 8] = g_reg[c][23:16];
            res.cipher_lo[63-8*c -: 8] = g_reg[c][15:8];
            res.cipher_lo[31-8*c -: 8] = g_reg[c][7:0];
        end
    end

endmodule

[rtl/aes_block_encrypt_chk.sv]
// Port-level checker for aes_block_encrypt, bound to the top level.
// Depends on aes_block_encrypt_macros.svh and aesbe_pkg.
`timescale 1ns / 1ps
`include "aes_block_encrypt_macros.svh"

module aes_block_encrypt_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input aesbe_pkg::aesbe_req_t req,
    input logic                  done,
    input logic                  cfg_ready
);

    `AESBE_NEXT(a_enc_busy, clk, rst_n, start && !busy && req.op == aesbe_pkg::OP_ENCRYPT, busy && !done)
    `AESBE_NEXT(a_load_idle, clk, rst_n, start && !busy && req.op == aesbe_pkg::OP_LOAD, !busy)
    `AESBE_NEXT(a_done_free, clk, rst_n, done, !busy && !done)
    `AESBE_SAME(a_done_busy, clk, rst_n, done, busy && !cfg_ready)

endmodule

bind aes_block_encrypt aes_block_encrypt_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .cfg_ready (cfg_ready)
);

[test/aes_block_encrypt_test.sv]
// Self-checking bench for aes_block_encrypt: key loads and block encrypts
// checked against a cipher predictor for round counts 10 to 14 and out-of-range settings.
// Depends on aesbe_pkg and aes_block_encrypt.
`timescale 1ns / 1ps

module aes_block_encrypt_test;

    localparam int SLOTS = 15;
    localparam int DRAIN_CYCLES = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    aesbe_pkg::aesbe_req_t req = '0;
    logic done;
    aesbe_pkg::aesbe_res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [aesbe_pkg::ROUNDS_W-1:0] cfg_data = '0;

    aesbe_pkg::aesbe_req_t request_queue[$];
    aesbe_pkg::aesbe_res_t cipher_expected[$];
    logic [127:0] key_store_model [SLOTS];
    logic [3:0] round_count;
    int send_idle_pct;
    int errors;

    aes_block_encrypt dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic aesbe_pkg::aesbe_res_t cipher_block(input aesbe_pkg::aesbe_req_t r);
        logic [7:0] g [4][4];
        logic [7:0] t [4][4];
        logic [7:0] a [4];
        logic [7:0] d [4];
        logic [127:0] blk;
        logic [127:0] key;
        logic [127:0] outv;
        int n;
        blk = {r.block_hi, r.block_lo};
        n = round_count < 10 ? 10 : (round_count > SLOTS - 1 ? SLOTS - 1 : round_count);
        for (int i = 0; i < 16; i++)
            g[i / 4][i % 4] = blk[127 - 8 * i -: 8];
        for (int k = 0; k <= n; k++)
        begin
            if (k > 0)
            begin
                for (int y = 0; y < 4; y++)
                    for (int x = 0; x < 4; x++)
                        t[y][x] = aesbe_pkg::SBOX[g[y][(x + y) % 4]];
                g = t;
                if (k < n)
                begin
                    for (int x = 0; x < 4; x++)
                    begin
                        for (int y = 0; y < 4; y++)
                        begin
                            a[y] = g[y][x];
                            d[y] = gf_double(g[y][x]);
                        end
                        g[0][x] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
                        g[1][x] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
                        g[2][x] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
                        g[3][x] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
                    end
                end
            end
            key = key_store_model[k];
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 4; x++)
                    g[y][x] ^= key[127 - 8 * (4 * x + y) -: 8];
        end
        for (int i = 0; i < 16; i++)
            outv[127 - 8 * i -: 8] = g[i / 4][i % 4];
        return '{cipher_hi: outv[127:64], cipher_lo: outv[63:0]};
    endfunction

    // driver: one request per accept, random gaps between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (req.op == aesbe_pkg::OP_ENCRYPT)
                    cipher_expected.push_back(cipher_block(req));
                else if (req.key_slot < SLOTS)
                    key_store_model[req.key_slot] = {req.block_hi, req.block_lo};
            end
            if (!start || !busy)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= request_queue.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (cipher_expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h_%h", res.cipher_hi, res.cipher_lo);
            end
            else if (res !== cipher_expected[0])
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h_%h got %h_%h",
                             cipher_expected[0].cipher_hi, cipher_expected[0].cipher_lo,
                             res.cipher_hi, res.cipher_lo);
                void'(cipher_expected.pop_front());
            end
            else
            begin
                void'(cipher_expected.pop_front());
            end
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_request(input logic op, input logic [3:0] slot,
                                 input logic [63:0] hi, input logic [63:0] lo);
        aesbe_pkg::aesbe_req_t r;
        r.op = op;
        r.key_slot = slot;
        r.block_hi = hi;
        r.block_lo = lo;
        request_queue.push_back(r);
    endtask

    task automatic drain();
        do @(posedge clk);
        while (request_queue.size() != 0 || start || cipher_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rounds(input logic [3:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        round_count = value;
        cfg_valid <= 1'b0;
    endtask

    logic [3:0] round_plan [8] = '{4'd14, 4'd0, 4'd12, 4'd15, 4'd11, 4'd13, 4'd10, 4'd9};

    initial
    begin
        errors = 0;
        round_count = 4'd10;
        send_idle_pct = 33;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every key slot, extremes first; slot 15 must be dropped
        queue_request(aesbe_pkg::OP_LOAD, 4'd0, '0, '0);
        queue_request(aesbe_pkg::OP_LOAD, 4'd1, '1, '1);
        for (int s = 2; s < SLOTS; s++)
            queue_request(aesbe_pkg::OP_LOAD, s[3:0], rand_word(), rand_word());
        queue_request(aesbe_pkg::OP_LOAD, 4'd15, '1, '0);
        queue_request(aesbe_pkg::OP_ENCRYPT, 4'd0, '0, '0);
        queue_request(aesbe_pkg::OP_ENCRYPT, 4'd15, '1, '1);
        queue_request(aesbe_pkg::OP_ENCRYPT, 4'd7, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_request(aesbe_pkg::OP_LOAD, 4'd10, '1, '0);
        queue_request(aesbe_pkg::OP_ENCRYPT, 4'd0, '1, '0);
        queue_request(aesbe_pkg::OP_ENCRYPT, 4'd0, '0, '1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            send_idle_pct = p < 3 ? 33 : (p < 6 ? 58 : 0);
            write_rounds(p == 7 ? 4'($urandom) : round_plan[p]);
            for (int i = 0; i < 235; i++)
            begin
                if ($urandom_range(9) < 7)
                    queue_request(aesbe_pkg::OP_ENCRYPT, 4'($urandom), rand_word(), rand_word());
                else
                    queue_request(aesbe_pkg::OP_LOAD, 4'($urandom_range(15)),
                                  rand_word(), rand_word());
            end
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/aesbe_pkg.sv
rtl/aesbe_key_store.sv
rtl/aesbe_col_unit.sv
rtl/aes_block_encrypt.sv
rtl/aes_block_encrypt_chk.sv
test/aes_block_encrypt_test.sv
